/* hw/rtl/nfg_pkg.sv */
package nfg_pkg;

   localparam int ResWidth = 48;

   localparam logic [2:0] FUNC_TABLE_WR = 3'd0;
   localparam logic [2:0] FUNC_GRID_WR  = 3'd1;
   localparam logic [2:0] FUNC_GRID_RD  = 3'd2;
   localparam logic [2:0] FUNC_SPREAD   = 3'd3;
   localparam logic [2:0] FUNC_GATHER   = 3'd4;

   localparam logic [1:0] CSR_GRID_LEN   = 2'd0;
   localparam logic [1:0] CSR_HALF_WIDTH = 2'd1;
   localparam logic [1:0] CSR_TABLE_STEP = 2'd2;

   localparam logic [12:0] GRID_LEN_RESET   = 13'd256;
   localparam logic [3:0]  HALF_WIDTH_RESET = 4'd4;
   localparam logic [22:0] TABLE_STEP_RESET = 23'd65472;

   typedef struct packed {
      logic [2:0]         func;
      logic [11:0]        addr;
      logic signed [31:0] value_re;
      logic signed [31:0] value_im;
      logic signed [23:0] node_pos;
   } req_type;

   typedef struct packed {
      logic signed [47:0] result_re;
      logic signed [47:0] result_im;
      logic [2:0]         echo_func;
   } rsp_type;

   typedef struct packed {
      logic signed [47:0] re;
      logic signed [47:0] im;
   } cell_type;

endpackage

/* hw/rtl/nfg_grid_mem.sv */
module nfg_grid_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  nfg_pkg::cell_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output nfg_pkg::cell_type  rd_data
);
   import nfg_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nfg_win_table.sv */
module nfg_win_table #(
   parameter int DEPTH = 1536,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [17:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [17:0]   rd_data_a,
   output logic [17:0]   rd_data_b
);
   logic [17:0] mem [DEPTH];
   logic [17:0] rd_a_ff;
   logic [17:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/nfft_gridding_convolution.sv */
// Table and grid writes pass S_EXEC and S_DONE before the result; grid reads add S_RD.
// Spread and gather pass S_SETUP, S_BASE and S_WRAP, which adds the grid length until
// the first cell is in range, then S_POS, S_TAB, S_INT, S_WGT, S_MUL and S_ACC for each
// of 2m+1 cells. One item is worked at a time, and the per-cell loop sets the rate.
// Synchronous active-high reset restores the control and CSR registers and then clears
// the grid memory cell by cell in S_CLEAR, during which no transaction is accepted.
module nfft_gridding_convolution #(
   parameter int GRID_SIZE      = 4096,
   parameter int TABLE_RES      = 1024,
   parameter int MAX_HALF_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nfg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nfg_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [22:0]      csr_wdata
);
   import nfg_pkg::*;

   localparam int TableDepth = (3 * TABLE_RES) / 2;
   localparam int TAW = $clog2(TableDepth);
   localparam int GAW = $clog2(GRID_SIZE);
   localparam int NW  = GAW + 1;
   localparam int HWW = $clog2(MAX_HALF_WIDTH + 1);
   localparam int PW  = 24 + NW + 1;
   localparam int LW  = NW + 2;
   localparam int DW  = 24 + HWW + 1;
   localparam int POW = DW - 1 + 23;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_EXEC  = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_SETUP = 4'd4;
   localparam logic [3:0] S_BASE  = 4'd5;
   localparam logic [3:0] S_WRAP  = 4'd6;
   localparam logic [3:0] S_POS   = 4'd7;
   localparam logic [3:0] S_TAB   = 4'd8;
   localparam logic [3:0] S_INT   = 4'd9;
   localparam logic [3:0] S_WGT   = 4'd10;
   localparam logic [3:0] S_MUL   = 4'd11;
   localparam logic [3:0] S_ACC   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [12:0] grid_len_ff;
   logic [3:0]  half_width_ff;
   logic [22:0] table_step_ff;
   logic [GAW-1:0] clr_ff, clr_in;
   req_type     item_ff, item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [HWW-1:0] m_ff, m_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic signed [LW-1:0] idx_s_ff, idx_s_in;
   logic [GAW-1:0] idx_ff, idx_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic [HWW:0] cnt_ff, cnt_in;
   logic [HWW:0] cell_last_ff, cell_last_in;
   logic [POW-1:0] pos_ff, pos_in;
   logic        oob_ff, oob_in;
   logic signed [35:0] ip_ff, ip_in;
   logic [17:0] w_ff, w_in;
   logic signed [66:0] mre_ff, mre_in, mim_ff, mim_in;
   logic signed [47:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   logic        g_we, g_re;
   logic [GAW-1:0] g_waddr, g_raddr;
   cell_type    g_wdata, g_rdata;
   logic        t_we, t_re;
   logic [TAW-1:0] t_waddr, t_ra, t_rb;
   logic [17:0] t_a, t_b;

   logic [DW-2:0] absd;
   logic signed [19:0] w_full;
   logic signed [47:0] sum_re, sum_im;
   logic        addr_grid_ok;
   logic        accept;

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                  input logic signed [66:0] prod);
      logic signed [50:0] s;
      s = 51'(a) + 51'($signed(prod[66:17]));
      if (s > 51'sh7FFFFFFFFFFF) begin
         return 48'sh7FFFFFFFFFFF;
      end else if (s < -51'sh800000000000) begin
         return -48'sh800000000000;
      end
      return s[47:0];
   endfunction

   nfg_grid_mem #(.DEPTH(GRID_SIZE), .AW(GAW)) u_grid (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_en   (g_re),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   nfg_win_table #(.DEPTH(TableDepth), .AW(TAW)) u_table (
      .clock     (clock),
      .wr_en     (t_we),
      .wr_addr   (t_waddr),
      .wr_data   (item_ff.value_re[17:0]),
      .rd_en     (t_re),
      .rd_addr_a (t_ra),
      .rd_addr_b (t_rb),
      .rd_data_a (t_a),
      .rd_data_b (t_b)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign addr_grid_ok = 32'(item_ff.addr) < GRID_SIZE;

   assign absd   = d_ff[DW-1] ? (DW-1)'(-d_ff) : d_ff[DW-2:0];
   assign w_full = 20'($signed({1'b0, t_a})) + 20'(ip_ff >>> 16);
   assign sum_re = sat_add((item_ff.func == FUNC_SPREAD) ? g_rdata.re : acc_re_ff, mre_ff);
   assign sum_im = sat_add((item_ff.func == FUNC_SPREAD) ? g_rdata.im : acc_im_ff, mim_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      idx_s_in     = idx_s_ff;
      idx_in       = idx_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      cell_last_in = cell_last_ff;
      pos_in       = pos_ff;
      oob_in       = oob_ff;
      ip_in        = ip_ff;
      w_in         = w_ff;
      mre_in       = mre_ff;
      mim_in       = mim_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      g_we    = 1'b0;
      g_re    = 1'b0;
      g_waddr = idx_ff;
      g_raddr = idx_ff;
      g_wdata = '{re: sum_re, im: sum_im};
      t_we    = 1'b0;
      t_re    = 1'b0;
      t_waddr = TAW'(item_ff.addr);
      t_ra    = pos_ff[32 +: TAW];
      t_rb    = pos_ff[32 +: TAW] + TAW'(1);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            g_wdata = '{re: '0, im: '0};
            clr_in  = clr_ff + GAW'(1);
            if (clr_ff == GAW'(GRID_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in   = req_data;
               acc_re_in = '0;
               acc_im_in = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (grid_len_ff < 13'd2) begin
               n_in = NW'(2);
            end else if (32'(grid_len_ff) > GRID_SIZE) begin
               n_in = NW'(GRID_SIZE);
            end else begin
               n_in = NW'(grid_len_ff);
            end
            if (half_width_ff == 4'd0) begin
               m_in = HWW'(1);
            end else if (32'(half_width_ff) > MAX_HALF_WIDTH) begin
               m_in = HWW'(MAX_HALF_WIDTH);
            end else begin
               m_in = HWW'(half_width_ff);
            end
            state_in = S_DONE;
            case (item_ff.func)
               FUNC_TABLE_WR: begin
                  t_we = 32'(item_ff.addr) < TableDepth;
               end
               FUNC_GRID_WR: begin
                  g_we    = addr_grid_ok;
                  g_waddr = GAW'(item_ff.addr);
                  g_wdata = '{re: 48'(item_ff.value_re), im: 48'(item_ff.value_im)};
               end
               FUNC_GRID_RD: begin
                  g_re     = 1'b1;
                  g_raddr  = GAW'(item_ff.addr);
                  state_in = S_RD;
               end
               FUNC_SPREAD, FUNC_GATHER: begin
                  state_in = S_SETUP;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD: begin
            if (addr_grid_ok) begin
               acc_re_in = g_rdata.re;
               acc_im_in = g_rdata.im;
            end
            state_in = S_DONE;
         end
         S_SETUP: begin
            p_in     = PW'(item_ff.node_pos * $signed({1'b0, n_ff}));
            state_in = S_BASE;
         end
         S_BASE: begin
            idx_s_in     = LW'($signed(p_ff[PW-1:24])) - $signed(LW'(m_ff));
            d_in         = DW'({m_ff, p_ff[23:0]});
            cnt_in       = '0;
            cell_last_in = {m_ff, 1'b0};
            state_in     = S_WRAP;
         end
         S_WRAP: begin
            if (idx_s_ff < 0) begin
               idx_s_in = idx_s_ff + $signed(LW'(n_ff));
            end else begin
               idx_in   = idx_s_ff[GAW-1:0];
               state_in = S_POS;
            end
         end
         S_POS: begin
            g_re     = 1'b1;
            pos_in   = POW'(absd * table_step_ff);
            state_in = S_TAB;
         end
         S_TAB: begin
            t_re     = 1'b1;
            oob_in   = (32'(pos_ff[POW-1:32]) + 32'd1) >= TableDepth;
            state_in = S_INT;
         end
         S_INT: begin
            ip_in    = 36'(($signed({1'b0, t_b}) - $signed({1'b0, t_a}))
                           * $signed({1'b0, pos_ff[31:16]}));
            state_in = S_WGT;
         end
         S_WGT: begin
            if (oob_ff || w_full < 0) begin
               w_in = '0;
            end else begin
               w_in = w_full[17:0];
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            if (item_ff.func == FUNC_SPREAD) begin
               mre_in = 67'(48'(item_ff.value_re) * $signed({1'b0, w_ff}));
               mim_in = 67'(48'(item_ff.value_im) * $signed({1'b0, w_ff}));
            end else begin
               mre_in = 67'(g_rdata.re * $signed({1'b0, w_ff}));
               mim_in = 67'(g_rdata.im * $signed({1'b0, w_ff}));
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            if (item_ff.func == FUNC_SPREAD) begin
               g_we = 1'b1;
            end else begin
               acc_re_in = sum_re;
               acc_im_in = sum_im;
            end
            d_in   = d_ff - $signed(DW'(25'h1000000));
            cnt_in = cnt_ff + (HWW+1)'(1);
            if (NW'(idx_ff) + NW'(1) == n_ff) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + GAW'(1);
            end
            state_in = (cnt_ff == cell_last_ff) ? S_DONE : S_POS;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{result_re: acc_re_ff, result_im: acc_im_ff,
                                echo_func: item_ff.func};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         grid_len_ff   <= GRID_LEN_RESET;
         half_width_ff <= HALF_WIDTH_RESET;
         table_step_ff <= TABLE_STEP_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_LEN:   grid_len_ff   <= csr_wdata[12:0];
               CSR_HALF_WIDTH: half_width_ff <= csr_wdata[3:0];
               CSR_TABLE_STEP: table_step_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_data_ff  <= rsp_data_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      idx_s_ff     <= idx_s_in;
      idx_ff       <= idx_in;
      d_ff         <= d_in;
      cnt_ff       <= cnt_in;
      cell_last_ff <= cell_last_in;
      pos_ff       <= pos_in;
      oob_ff       <= oob_in;
      ip_ff        <= ip_in;
      w_ff         <= w_in;
      mre_ff       <= mre_in;
      mim_ff       <= mim_in;
      acc_re_ff    <= acc_re_in;
      acc_im_ff    <= acc_im_in;
   end

`ifndef SYNTHESIS
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("transaction accepted during grid clear");

   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished item produced no result");

   a_cell_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POS) |-> (cnt_ff <= cell_last_ff))
      else $error("cell count past window");
`endif

endmodule

/* tb/sv/nfg_scoreboard.sv */
module nfg_scoreboard
   import nfg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_wdata,
   input  logic        drain,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GridCells  = 4096;
   localparam int TableDepth = 1536;
   localparam int MaxHalf    = 8;
   localparam longint S48Max = 64'sh7FFF_FFFF_FFFF;
   localparam longint S48Min = -S48Max - 1;

   longint      cell_re [GridCells];
   longint      cell_im [GridCells];
   longint      window_lut [TableDepth];
   logic [12:0] grid_len;
   logic [3:0]  half_width;
   logic [22:0] table_step;
   rsp_type     awaited_rsp [$];
   logic        drained = 1'b0;

   initial fail_count = 0;

   task automatic report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic longint clamp48(input longint v);
      if (v > S48Max) return S48Max;
      if (v < S48Min) return S48Min;
      return v;
   endfunction

   function automatic longint weighted(input longint v, input longint w);
      longint lo;
      longint hi;
      lo = v & 64'h1FFFF;
      hi = (v - lo) >>> 17;
      return hi * w + ((lo * w) >>> 17);
   endfunction

   function automatic longint window_weight(input longint distance);
      longint d;
      longint pos;
      longint idx;
      longint frac;
      longint a;
      longint b;
      longint w;
      d = (distance < 0) ? -distance : distance;
      pos = d * longint'(table_step);
      idx = pos >>> 32;
      frac = (pos >>> 16) & 64'hFFFF;
      if (idx + 1 >= TableDepth) return 0;
      a = window_lut[idx];
      b = window_lut[idx + 1];
      w = a + (((b - a) * frac) >>> 16);
      if (w < 0) w = 0;
      return w;
   endfunction

   function automatic rsp_type grid_op(input req_type r);
      rsp_type o;
      longint vre;
      longint vim;
      longint x;
      longint n;
      longint m;
      longint p;
      longint c;
      longint idx;
      longint w;
      longint acc_re;
      longint acc_im;
      vre = longint'($signed(r.value_re));
      vim = longint'($signed(r.value_im));
      x = longint'($signed(r.node_pos));
      acc_re = 0;
      acc_im = 0;
      case (r.func)
         FUNC_TABLE_WR: begin
            if (r.addr < TableDepth) window_lut[r.addr] = longint'(r.value_re[17:0]);
         end
         FUNC_GRID_WR: begin
            cell_re[r.addr] = vre;
            cell_im[r.addr] = vim;
         end
         FUNC_GRID_RD: begin
            acc_re = cell_re[r.addr];
            acc_im = cell_im[r.addr];
         end
         FUNC_SPREAD, FUNC_GATHER: begin
            n = grid_len;
            m = half_width;
            if (n < 2) n = 2;
            if (n > GridCells) n = GridCells;
            if (m < 1) m = 1;
            if (m > MaxHalf) m = MaxHalf;
            p = x * n;
            c = p >>> 24;
            for (longint l = c - m; l <= c + m; l++) begin
               idx = l % n;
               if (idx < 0) idx += n;
               w = window_weight(p - (l <<< 24));
               if (r.func == FUNC_SPREAD) begin
                  cell_re[idx] = clamp48(cell_re[idx] + weighted(vre, w));
                  cell_im[idx] = clamp48(cell_im[idx] + weighted(vim, w));
               end else begin
                  acc_re = clamp48(acc_re + weighted(cell_re[idx], w));
                  acc_im = clamp48(acc_im + weighted(cell_im[idx], w));
               end
            end
         end
         default: begin
         end
      endcase
      o.result_re = acc_re[47:0];
      o.result_im = acc_im[47:0];
      o.echo_func = r.func;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < GridCells; i++) begin
            cell_re[i] = 0;
            cell_im[i] = 0;
         end
         grid_len = GRID_LEN_RESET;
         half_width = HALF_WIDTH_RESET;
         table_step = TABLE_STEP_RESET;
         awaited_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_LEN:   grid_len = csr_wdata[12:0];
               CSR_HALF_WIDTH: half_width = csr_wdata[3:0];
               CSR_TABLE_STEP: table_step = csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report($sformatf("result with no transaction pending, func %0d",
                                rsp_data.echo_func));
            end else begin
               e = awaited_rsp.pop_front();
               if (rsp_data.echo_func !== e.echo_func)
                  report($sformatf("echo_func got %0d expected %0d",
                                   rsp_data.echo_func, e.echo_func));
               if (rsp_data.result_re !== e.result_re)
                  report($sformatf("func %0d result_re got %0d expected %0d", e.echo_func,
                                   rsp_data.result_re, e.result_re));
               if (rsp_data.result_im !== e.result_im)
                  report($sformatf("func %0d result_im got %0d expected %0d", e.echo_func,
                                   rsp_data.result_im, e.result_im));
            end
         end
         if (req_valid && req_ready) awaited_rsp.push_back(grid_op(req_data));
         if (drain && !drained) begin
            drained <= 1'b1;
            if (awaited_rsp.size() != 0)
               report($sformatf("%0d results never arrived", awaited_rsp.size()));
         end
      end
   end

endmodule

/* tb/sv/nfft_gridding_convolution_tb.sv */
module nfft_gridding_convolution_tb;
   import nfg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_GRID_LEN;
   logic [22:0] csr_wdata = '0;
   logic        drain = 1'b0;
   int          fail_count;
   int          n_sent = 0;
   int          n_done = 0;
   int          send_idle_pct = 31;
   int          recv_idle_pct = 46;

   nfft_gridding_convolution u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nfg_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .drain      (drain),
      .fail_count (fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** nfft_gridding_convolution: FAILED **");
      $finish;
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) n_sent <= n_sent + 1;
         if (rsp_valid && rsp_ready) n_done <= n_done + 1;
      end
   end

   task automatic send(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_op(input logic [2:0] func, input logic [11:0] addr,
                          input logic [31:0] vre, input logic [31:0] vim,
                          input logic [23:0] pos);
      req_type item;
      item.func = func;
      item.addr = addr;
      item.value_re = vre;
      item.value_im = vim;
      item.node_pos = pos;
      send(item);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (n_done != n_sent) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_regs(input logic [12:0] len, input logic [3:0] hw,
                             input logic [22:0] step);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_GRID_LEN;
      csr_wdata <= 23'(len);
      @(negedge clock);
      csr_index <= CSR_HALF_WIDTH;
      csr_wdata <= 23'(hw);
      @(negedge clock);
      csr_index <= CSR_TABLE_STEP;
      csr_wdata <= step;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic edge_pair();
      send_op(FUNC_SPREAD, 12'd0, 32'h00100000, 32'hFFF00000, 24'h0);
      send_op(FUNC_GATHER, 12'd0, 32'h0, 32'h0, 24'h0);
      settle();
   endtask

   function automatic req_type random_item();
      req_type item;
      int pick;
      pick = $urandom_range(99);
      item.value_re = $urandom;
      item.value_im = $urandom;
      item.node_pos = 24'($urandom);
      item.addr = ($urandom_range(1)) ? 12'($urandom) : 12'($urandom_range(299));
      if (pick < 30) item.func = FUNC_SPREAD;
      else if (pick < 60) item.func = FUNC_GATHER;
      else if (pick < 75) item.func = FUNC_GRID_RD;
      else if (pick < 85) item.func = FUNC_GRID_WR;
      else if (pick < 93) item.func = FUNC_TABLE_WR;
      else item.func = 3'($urandom_range(7, 5));
      return item;
   endfunction

   typedef struct {
      logic [12:0] len;
      logic [3:0]  hw;
      logic [22:0] step;
   } setting_type;

   // Every setting keeps (m+1)*step below 127*256, so no window lookup
   // goes past the filled part of the table.
   setting_type settings [9] = '{
      '{13'd256, 4'd4, 23'd6400},
      '{13'd16, 4'd8, 23'd3584},
      '{13'd2, 4'd8, 23'd3584},
      '{13'd0, 4'd0, 23'd1},
      '{13'd4096, 4'd1, 23'd16000},
      '{13'd8191, 4'd15, 23'd3600},
      '{13'd1000, 4'd3, 23'd8000},
      '{13'd64, 4'd2, 23'd10000},
      '{13'd300, 4'd5, 23'd5400}
   };

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 128; i++)
         send_op(FUNC_TABLE_WR, 12'(i), (i == 0) ? 32'h3FFFF : (i == 1) ? 32'h0 : $urandom,
                 $urandom, 24'($urandom));
      send_op(FUNC_TABLE_WR, 12'd1534, 32'h0001F000, 32'h0, 24'h0);
      send_op(FUNC_TABLE_WR, 12'd1535, 32'hFFFFFFFF, 32'h0, 24'h0);
      send_op(FUNC_TABLE_WR, 12'd1536, 32'h0003FFFF, 32'h0, 24'h0);
      send_op(FUNC_TABLE_WR, 12'd4095, 32'h0, 32'h0, 24'h0);

      send_op(FUNC_GRID_WR, 12'd0, 32'h7FFFFFFF, 32'h80000000, 24'h0);
      send_op(FUNC_GRID_WR, 12'd4095, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF);
      send_op(FUNC_GRID_RD, 12'd0, 32'h0, 32'h0, 24'h0);
      send_op(FUNC_GRID_RD, 12'd4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'h0);
      send_op(FUNC_GRID_RD, 12'd2048, 32'h0, 32'h0, 24'h0);
      send_op(3'd5, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
      send_op(3'd6, 12'd0, 32'h0, 32'h0, 24'h0);
      send_op(3'd7, 12'hABC, 32'h55555555, 32'hAAAAAAAA, 24'h555555);
      settle();

      write_regs(13'd256, 4'd4, 23'd6400);
      send_op(FUNC_SPREAD, 12'd0, 32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF);
      send_op(FUNC_SPREAD, 12'd0, 32'h80000000, 32'h7FFFFFFF, 24'h800000);
      send_op(FUNC_SPREAD, 12'd0, 32'h12345678, 32'hEDCBA987, 24'h000000);
      send_op(FUNC_GATHER, 12'd0, 32'h0, 32'h0, 24'h7FFFFF);
      send_op(FUNC_GATHER, 12'd0, 32'h0, 32'h0, 24'h800000);
      send_op(FUNC_GATHER, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'h000000);
      send_op(FUNC_GRID_RD, 12'd128, 32'h0, 32'h0, 24'h0);
      send_op(FUNC_GRID_RD, 12'd255, 32'h0, 32'h0, 24'h0);
      settle();

      // A node at zero puts the outer cells exactly at the last table pair,
      // then one step past the end, then far beyond it.
      write_regs(13'd16, 4'd1, 23'd392704);
      edge_pair();
      write_regs(13'd16, 4'd1, 23'd392960);
      edge_pair();
      write_regs(13'd16, 4'd1, 23'd4194304);
      edge_pair();

      for (int ph = 0; ph < 9; ph++) begin
         write_regs(settings[ph].len, settings[ph].hw, settings[ph].step);
         if (ph < 3) begin
            send_idle_pct = 31;
            recv_idle_pct = 46;
         end else if (ph < 6) begin
            send_idle_pct = 46;
            recv_idle_pct = 31;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 2) begin
            send_op(FUNC_SPREAD, 12'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF);
            send_op(FUNC_GATHER, 12'd0, 32'h0, 32'h0, 24'h800000);
         end
         for (int k = 0; k < 60; k++) send(random_item());
         settle();
      end

      drain <= 1'b1;
      repeat (3) @(negedge clock);
      if (fail_count == 0) begin
         $display("** nfft_gridding_convolution: PASSED **");
      end else begin
         $display("** nfft_gridding_convolution: FAILED **");
      end
      $finish;
   end

endmodule
